FILE: rtl/hough_line_accumulator_defines.svh
// assertion helpers shared by the rtl
`ifndef HOUGH_LINE_ACCUMULATOR_DEFINES_SVH
`define HOUGH_LINE_ACCUMULATOR_DEFINES_SVH

// checked only out of reset
`define HLA_ASSERT(name, clk, rst, prop, msg) \
   name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked at every edge, reset included
`define HLA_ASSERT_ALWAYS(name, clk, prop, msg) \
   name: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: rtl/hla_pkg.sv
package hla_pkg;

   localparam int ANGLES = 180;

   typedef enum logic [1:0] {
      OP_VOTE  = 2'd0,
      OP_READ  = 2'd1,
      OP_CLEAR = 2'd2,
      OP_NOP   = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      CSR_IMAGE_WIDTH  = 2'd0,
      CSR_IMAGE_HEIGHT = 2'd1,
      CSR_RHO_OFFSET   = 2'd2,
      CSR_THRESHOLD    = 2'd3
   } csr_index_type;

   // transaction moving down the row of cells
   typedef struct packed {
      logic               valid;
      logic               is_read;
      logic signed [9:0]  dx;
      logic signed [9:0]  dy;
      logic [9:0]         rho_index;
      logic [7:0]         angle_index;
   } token_type;

   // shift and subtract quotient, only used while building constants
   function automatic longint unsigned udiv64(input longint unsigned num,
                                              input longint unsigned den);
      longint unsigned q;
      longint unsigned r;
      q = '0;
      r = '0;
      for (int i = 63; i >= 0; i--) begin
         r = {r[62:0], num[i]};
         if (r >= den) begin
            r    = r - den;
            q[i] = 1'b1;
         end
      end
      return q;
   endfunction

   // q2.14 cosine or sine from a taylor series in q28, angle scale 3.14/180
   function automatic logic signed [15:0] trig_q14(input int unsigned t, input bit want_sin);
      longint unsigned a;
      longint unsigned term;
      longint          c;
      longint          s;
      longint          v;
      longint unsigned mag;
      longint unsigned q;
      a    = udiv64(longint'(t) * 64'd314 * (64'd1 << 28), 64'd18000);
      term = 64'd1 << 28;
      c    = longint'(term);
      s    = 0;
      for (int n = 1; n <= 31; n++) begin
         term = udiv64((term * a) >> 28, 64'(n));
         if ((n & 1) != 0) begin
            if ((n & 2) != 0) s = s - longint'(term);
            else s = s + longint'(term);
         end else begin
            if ((n & 2) != 0) c = c - longint'(term);
            else c = c + longint'(term);
         end
      end
      v   = want_sin ? s : c;
      mag = (v < 0) ? longint'(-v) : longint'(v);
      q   = (mag + 64'd8192) >> 14;
      return (v < 0) ? -16'(q) : 16'(q);
   endfunction

endpackage

FILE: rtl/hla_cell.sv
module hla_cell #(
   parameter int ANGLE      = 0,
   parameter int RHO_BINS   = 1024,
   parameter int COUNT_BITS = 19,
   localparam int RB        = $clog2(RHO_BINS)
) (
   input  logic                  clock,
   input  logic                  reset,
   input  hla_pkg::token_type    tok_in,
   output hla_pkg::token_type    tok_out,
   input  logic                  lag_valid_in,
   input  logic [COUNT_BITS-1:0] lag_peak_in,
   input  logic [COUNT_BITS-1:0] lag_count_in,
   output logic                  lag_valid_out,
   output logic [COUNT_BITS-1:0] lag_peak_out,
   output logic [COUNT_BITS-1:0] lag_count_out,
   input  logic [9:0]            rho_offset,
   input  logic                  clear_en,
   input  logic [RB-1:0]         clear_addr
);

   localparam logic signed [15:0] COS_C = hla_pkg::trig_q14(ANGLE, 1'b0);
   localparam logic signed [15:0] SIN_C = hla_pkg::trig_q14(ANGLE, 1'b1);
   localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

   logic [COUNT_BITS-1:0] mem [RHO_BINS];

   hla_pkg::token_type    tok_ff;
   logic                  hit_ff, hit_in;
   logic [RB-1:0]         addr_ff, addr_in;
   logic [COUNT_BITS-1:0] rdata_ff;
   logic                  lag_valid_ff;
   logic [COUNT_BITS-1:0] lag_peak_ff, lag_peak_in_v;
   logic [COUNT_BITS-1:0] lag_count_ff, lag_count_in_v;
   logic [COUNT_BITS-1:0] bumped;
   logic signed [26:0]    sum;
   logic signed [12:0]    quot;
   logic signed [15:0]    row;
   logic [15:0]           rho_ext;

   always_comb begin
      sum = 27'(tok_in.dx) * 27'(COS_C) + 27'(tok_in.dy) * 27'(SIN_C);
      // truncate toward zero
      quot = sum[26:14];
      if (sum[26] && (sum[13:0] != 14'd0)) quot = quot + 13'sd1;
      row     = 16'(quot) + $signed({6'b0, rho_offset});
      rho_ext = {6'b0, tok_in.rho_index};
      if (tok_in.is_read) begin
         hit_in  = tok_in.valid && (tok_in.angle_index == 8'(ANGLE))
                   && (rho_ext < 16'(RHO_BINS));
         addr_in = rho_ext[RB-1:0];
      end else begin
         hit_in  = tok_in.valid && (row >= 16'sd0) && (row < $signed(16'(RHO_BINS)));
         addr_in = row[RB-1:0];
      end
   end

   assign bumped = (rdata_ff == COUNT_MAX) ? rdata_ff : rdata_ff + 1'b1;

   always_comb begin
      lag_peak_in_v  = lag_peak_in;
      lag_count_in_v = lag_count_in;
      if (tok_ff.valid && hit_ff) begin
         if (tok_ff.is_read) lag_count_in_v = rdata_ff;
         else if (bumped > lag_peak_in) lag_peak_in_v = bumped;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tok_ff.valid <= 1'b0;
         lag_valid_ff <= 1'b0;
      end else begin
         tok_ff       <= tok_in;
         lag_valid_ff <= lag_valid_in;
      end
      hit_ff       <= hit_in;
      addr_ff      <= addr_in;
      lag_peak_ff  <= lag_peak_in_v;
      lag_count_ff <= lag_count_in_v;
   end

   // read now, write back in the next cycle
   always_ff @(posedge clock) begin
      if (tok_in.valid) rdata_ff <= mem[addr_in];
      if (clear_en) mem[clear_addr] <= '0;
      else if (tok_ff.valid && !tok_ff.is_read && hit_ff) mem[addr_ff] <= bumped;
   end

   assign tok_out       = tok_ff;
   assign lag_valid_out = lag_valid_ff;
   assign lag_peak_out  = lag_peak_ff;
   assign lag_count_out = lag_count_ff;

endmodule

FILE: rtl/hla_divider.sv
module hla_divider #(
   parameter int COUNT_BITS = 19
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  logic [COUNT_BITS+7:0]   numer,
   input  logic [COUNT_BITS-1:0]   denom,
   output logic                    done,
   output logic [7:0]              quotient
);

   logic                  run_ff;
   logic                  done_ff;
   logic [2:0]            step_ff;
   logic [COUNT_BITS-1:0] rem_ff, rem_in;
   logic [COUNT_BITS-1:0] denom_ff;
   logic [7:0]            low_ff;
   logic [7:0]            q_ff;
   logic [COUNT_BITS:0]   trial;
   logic                  ge;

   always_comb begin
      trial  = {rem_ff, low_ff[7]};
      ge     = trial >= {1'b0, denom_ff};
      rem_in = ge ? COUNT_BITS'(trial - {1'b0, denom_ff}) : trial[COUNT_BITS-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            run_ff  <= 1'b1;
            step_ff <= '0;
         end else if (run_ff) begin
            step_ff <= step_ff + 3'd1;
            if (step_ff == 3'd7) begin
               run_ff  <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
      if (start) begin
         rem_ff   <= numer[COUNT_BITS+7:8];
         low_ff   <= numer[7:0];
         denom_ff <= denom;
         q_ff     <= '0;
      end else if (run_ff) begin
         rem_ff <= rem_in;
         low_ff <= {low_ff[6:0], 1'b0};
         q_ff   <= {q_ff[6:0], ge};
      end
   end

   assign done     = done_ff;
   assign quotient = q_ff;

endmodule

FILE: rtl/hough_line_accumulator.sv
// channel   ports                             transfer
// request   start, busy, req_*                start high while busy low
// response  rsp_valid, rsp_*                  one cycle strobe, always taken
// csr       csr_write_en, csr_index, csr_*    write enable high, no wait
//
// a vote runs down 180 angle cells, one cell per cycle; busy stays high until it is through.
// a read runs the same row of cells, then an 8 step divide; the strobe comes when the
// divide is done, and busy falls in the same cycle that the strobe is high.
// a clear, and the pass after reset, sweep all cells one rho row a cycle with busy high.
// ops with no work leave busy low.
// the response cannot be stalled; busy gates every new transaction.
`include "hough_line_accumulator_defines.svh"

module hough_line_accumulator #(
   parameter int RHO_BINS   = 1024,
   parameter int COUNT_BITS = 19
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  logic [1:0]            req_op,
   input  logic [8:0]            req_pixel_x,
   input  logic [8:0]            req_pixel_y,
   input  logic [7:0]            req_pixel_value,
   input  logic [9:0]            req_rho_index,
   input  logic [7:0]            req_angle_index,
   output logic                  rsp_valid,
   output logic [COUNT_BITS-1:0] rsp_vote_count,
   output logic [7:0]            rsp_scaled_value,
   output logic                  rsp_above_threshold,
   output logic [COUNT_BITS-1:0] rsp_peak_count,
   input  logic                  csr_write_en,
   input  logic [1:0]            csr_index,
   input  logic [9:0]            csr_wdata
);

   localparam int RB = $clog2(RHO_BINS);
   localparam int N  = hla_pkg::ANGLES;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_CHAIN,
      ST_DIV
   } state_type;

   state_type             state_ff;
   logic [RB-1:0]         clr_addr_ff;
   logic [COUNT_BITS-1:0] peak_ff;
   logic                  is_read_ff;
   logic                  lag0_valid_ff;
   logic [COUNT_BITS-1:0] count_ff;
   logic [9:0]            width_ff, height_ff, offset_ff;
   logic [7:0]            thresh_ff;
   logic                  rsp_valid_ff;
   logic [COUNT_BITS-1:0] rsp_count_ff, rsp_peak_ff;
   logic [7:0]            rsp_scaled_ff;
   logic                  rsp_above_ff;

   logic                  accept;
   logic                  launch;
   logic                  div_start;
   logic                  div_done;
   logic [7:0]            div_q;
   logic [7:0]            scaled;
   logic [COUNT_BITS+7:0] numer;

   hla_pkg::token_type    tok [N+1];
   logic                  lag_valid [N+1];
   logic [COUNT_BITS-1:0] lag_peak  [N+1];
   logic [COUNT_BITS-1:0] lag_count [N+1];

   assign busy   = (state_ff != ST_IDLE);
   assign accept = start && !busy;
   assign launch = accept && ((hla_pkg::op_type'(req_op) == hla_pkg::OP_READ)
                   || ((hla_pkg::op_type'(req_op) == hla_pkg::OP_VOTE)
                       && (req_pixel_value != 8'hFF)));

   always_comb begin
      tok[0].valid       = launch;
      tok[0].is_read     = (hla_pkg::op_type'(req_op) == hla_pkg::OP_READ);
      tok[0].dx          = $signed({1'b0, req_pixel_x}) - $signed({1'b0, width_ff[9:1]});
      tok[0].dy          = $signed({1'b0, req_pixel_y}) - $signed({1'b0, height_ff[9:1]});
      tok[0].rho_index   = req_rho_index;
      tok[0].angle_index = req_angle_index;
   end

   assign lag_valid[0] = lag0_valid_ff;
   assign lag_peak[0]  = peak_ff;
   assign lag_count[0] = '0;

   for (genvar g = 0; g < N; g++) begin : g_cell
      hla_cell #(
         .ANGLE      (g),
         .RHO_BINS   (RHO_BINS),
         .COUNT_BITS (COUNT_BITS)
      ) u_cell (
         .clock         (clock),
         .reset         (reset),
         .tok_in        (tok[g]),
         .tok_out       (tok[g+1]),
         .lag_valid_in  (lag_valid[g]),
         .lag_peak_in   (lag_peak[g]),
         .lag_count_in  (lag_count[g]),
         .lag_valid_out (lag_valid[g+1]),
         .lag_peak_out  (lag_peak[g+1]),
         .lag_count_out (lag_count[g+1]),
         .rho_offset    (offset_ff),
         .clear_en      (state_ff == ST_CLEAR),
         .clear_addr    (clr_addr_ff)
      );
   end

   // count*255 as count*256 - count
   assign numer     = {lag_count[N], 8'd0} - {8'd0, lag_count[N]};
   assign div_start = (state_ff == ST_CHAIN) && lag_valid[N] && is_read_ff;
   assign scaled    = (peak_ff == '0) ? 8'd0 : div_q;

   hla_divider #(
      .COUNT_BITS (COUNT_BITS)
   ) u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .numer    (numer),
      .denom    (peak_ff),
      .done     (div_done),
      .quotient (div_q)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= 10'd512;
         height_ff <= 10'd512;
         offset_ff <= 10'd362;
         thresh_ff <= 8'd150;
      end else if (csr_write_en) begin
         case (hla_pkg::csr_index_type'(csr_index))
            hla_pkg::CSR_IMAGE_WIDTH:  width_ff  <= csr_wdata;
            hla_pkg::CSR_IMAGE_HEIGHT: height_ff <= csr_wdata;
            hla_pkg::CSR_RHO_OFFSET:   offset_ff <= csr_wdata;
            hla_pkg::CSR_THRESHOLD:    thresh_ff <= csr_wdata[7:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         clr_addr_ff   <= '0;
         peak_ff       <= '0;
         lag0_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         lag0_valid_ff <= launch;
         rsp_valid_ff  <= 1'b0;
         unique case (state_ff)
            ST_CLEAR: begin
               clr_addr_ff <= clr_addr_ff + 1'b1;
               if (clr_addr_ff == RB'(RHO_BINS - 1)) state_ff <= ST_IDLE;
            end
            ST_IDLE: begin
               if (launch) begin
                  state_ff <= ST_CHAIN;
               end else if (accept && (hla_pkg::op_type'(req_op) == hla_pkg::OP_CLEAR)) begin
                  state_ff    <= ST_CLEAR;
                  clr_addr_ff <= '0;
                  peak_ff     <= '0;
               end
            end
            ST_CHAIN: begin
               if (lag_valid[N]) begin
                  if (is_read_ff) begin
                     state_ff <= ST_DIV;
                  end else begin
                     peak_ff  <= lag_peak[N];
                     state_ff <= ST_IDLE;
                  end
               end
            end
            ST_DIV: begin
               if (div_done) begin
                  rsp_valid_ff <= 1'b1;
                  state_ff     <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
      if (launch) is_read_ff <= tok[0].is_read;
      if (div_start) count_ff <= lag_count[N];
      if (state_ff == ST_DIV && div_done) begin
         rsp_count_ff  <= count_ff;
         rsp_scaled_ff <= scaled;
         rsp_above_ff  <= scaled > thresh_ff;
         rsp_peak_ff   <= peak_ff;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_vote_count      = rsp_count_ff;
   assign rsp_scaled_value    = rsp_scaled_ff;
   assign rsp_above_threshold = rsp_above_ff;
   assign rsp_peak_count      = rsp_peak_ff;

   `HLA_ASSERT(a_chain_end_in_chain, clock, reset, lag_valid[N] |-> state_ff == ST_CHAIN, "chain result outside chain state")
   `HLA_ASSERT(a_div_done_in_div, clock, reset, div_done |-> state_ff == ST_DIV, "divider finished outside divide state")
   `HLA_ASSERT(a_count_le_peak, clock, reset, rsp_valid |-> rsp_vote_count <= rsp_peak_count, "read count above peak")
   `HLA_ASSERT_ALWAYS(a_reset_clears, clock, reset |=> state_ff == ST_CLEAR && !rsp_valid, "reset did not start clearing pass")

endmodule

FILE: test/hough_line_accumulator_test.sv
module hough_line_accumulator_test;

   localparam int RHO_ROWS   = 1024;
   localparam int CNT_BITS   = 19;
   localparam int CYCLE_CAP  = 4000000;
   localparam int NANG       = hla_pkg::ANGLES;

   typedef struct {
      logic [CNT_BITS-1:0] count;
      logic [7:0]          scaled;
      logic                flag;
      logic [CNT_BITS-1:0] peak;
   } report_type;

   class scoreboard_type;
      logic [CNT_BITS-1:0] cells[RHO_ROWS*NANG];
      logic [CNT_BITS-1:0] peak;
      int                  cos_tab[NANG];
      int                  sin_tab[NANG];
      int unsigned         width_reg, height_reg, offset_reg, thresh_reg;
      report_type          pending[$];
      int                  errors;

      function new();
         longint unsigned a;
         longint unsigned term;
         longint          c;
         longint          s;
         for (int t = 0; t < NANG; t++) begin
            a    = (longint'(t) * 314 * (64'd1 << 28)) / 18000;
            term = 64'd1 << 28;
            c    = longint'(term);
            s    = 0;
            for (int n = 1; n <= 31; n++) begin
               term = ((term * a) >> 28) / n;
               if (n % 2 == 1) s = (((n - 1) / 2) % 2 == 1) ? s - longint'(term) : s + longint'(term);
               else c = ((n / 2) % 2 == 1) ? c - longint'(term) : c + longint'(term);
            end
            cos_tab[t] = to_q14(c);
            sin_tab[t] = to_q14(s);
         end
         wipe();
         width_reg = 512; height_reg = 512; offset_reg = 362; thresh_reg = 150;
         errors = 0;
      endfunction

      function int to_q14(longint v);
         longint m;
         m = (v < 0) ? -v : v;
         m = (m + 8192) >>> 14;
         return (v < 0) ? -int'(m) : int'(m);
      endfunction

      function void wipe();
         foreach (cells[i]) cells[i] = '0;
         peak = '0;
      endfunction

      // store row hit by pixel (x,y) at angle t, may fall outside the store
      function int rho_row(int x, int y, int t);
         int dx, dy, sum;
         dx  = x - int'(width_reg / 2);
         dy  = y - int'(height_reg / 2);
         sum = dx * cos_tab[t] + dy * sin_tab[t];
         return sum / 16384 + int'(offset_reg);
      endfunction

      function void set_reg(hla_pkg::csr_index_type idx, int unsigned val);
         case (idx)
            hla_pkg::CSR_IMAGE_WIDTH:  width_reg  = val;
            hla_pkg::CSR_IMAGE_HEIGHT: height_reg = val;
            hla_pkg::CSR_RHO_OFFSET:   offset_reg = val;
            hla_pkg::CSR_THRESHOLD:    thresh_reg = val;
         endcase
      endfunction

      function void note_request(hla_pkg::op_type op, int x, int y, int pv, int rho, int ang);
         int         row;
         report_type r;
         longint     q;
         case (op)
            hla_pkg::OP_VOTE: if (pv < 255) begin
               for (int t = 0; t < NANG; t++) begin
                  row = rho_row(x, y, t);
                  if (row >= 0 && row < RHO_ROWS) begin
                     if (cells[row*NANG+t] != {CNT_BITS{1'b1}})
                        cells[row*NANG+t] = cells[row*NANG+t] + 1'b1;
                     if (cells[row*NANG+t] > peak) peak = cells[row*NANG+t];
                  end
               end
            end
            hla_pkg::OP_READ: begin
               r.count = (rho < RHO_ROWS && ang < NANG) ? cells[rho*NANG+ang] : '0;
               r.scaled = '0;
               if (peak != 0) begin
                  q = (longint'(r.count) * 255) / longint'(peak);
                  r.scaled = (q > 255) ? 8'd255 : 8'(q);
               end
               r.flag = r.scaled > thresh_reg;
               r.peak = peak;
               pending.push_back(r);
            end
            hla_pkg::OP_CLEAR: wipe();
            default: ;
         endcase
      endfunction

      function void check_result(logic [CNT_BITS-1:0] count, logic [7:0] scaled,
                                 logic flag, logic [CNT_BITS-1:0] pk);
         report_type e;
         if (pending.size() == 0) begin
            $error("unexpected read result, count %0d", count);
            errors++;
            return;
         end
         e = pending.pop_front();
         if (count !== e.count) begin
            $error("vote_count expected %0d actual %0d", e.count, count); errors++;
         end
         if (scaled !== e.scaled) begin
            $error("scaled_value expected %0d actual %0d", e.scaled, scaled); errors++;
         end
         if (flag !== e.flag) begin
            $error("above_threshold expected %0d actual %0d", e.flag, flag); errors++;
         end
         if (pk !== e.peak) begin
            $error("peak_count expected %0d actual %0d", e.peak, pk); errors++;
         end
      endfunction
   endclass

   logic                clock;
   logic                reset;
   logic                start;
   logic                busy;
   logic [1:0]          req_op;
   logic [8:0]          req_pixel_x;
   logic [8:0]          req_pixel_y;
   logic [7:0]          req_pixel_value;
   logic [9:0]          req_rho_index;
   logic [7:0]          req_angle_index;
   logic                rsp_valid;
   logic [CNT_BITS-1:0] rsp_vote_count;
   logic [7:0]          rsp_scaled_value;
   logic                rsp_above_threshold;
   logic [CNT_BITS-1:0] rsp_peak_count;
   logic                csr_write_en;
   logic [1:0]          csr_index;
   logic [9:0]          csr_wdata;

   scoreboard_type sb;
   int             cycles = 0;
   int             last_x, last_y;

   hough_line_accumulator dut (.*);

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_CAP) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   // transaction monitor: sees pre-edge values
   always @(posedge clock) begin
      if (!reset) begin
         if (start && !busy)
            sb.note_request(hla_pkg::op_type'(req_op), req_pixel_x, req_pixel_y,
                            req_pixel_value, req_rho_index, req_angle_index);
         if (rsp_valid)
            sb.check_result(rsp_vote_count, rsp_scaled_value, rsp_above_threshold,
                            rsp_peak_count);
      end
   end

   task automatic send(hla_pkg::op_type op, int x, int y, int pv, int rho, int ang);
      int gap;
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 12);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_op          <= op;
      req_pixel_x     <= 9'(x);
      req_pixel_y     <= 9'(y);
      req_pixel_value <= 8'(pv);
      req_rho_index   <= 10'(rho);
      req_angle_index <= 8'(ang);
      start           <= 1'b1;
      do @(posedge clock); while (busy);
      if (op == hla_pkg::OP_VOTE && pv < 255) begin
         last_x = x;
         last_y = y;
      end
   endtask

   task automatic drain();
      start <= 1'b0;
      do @(posedge clock); while (sb.pending.size() != 0 || busy);
      // a vote leaves no result, so give it time to finish
      repeat (250) @(posedge clock);
   endtask

   task automatic write_reg(hla_pkg::csr_index_type idx, int unsigned val);
      csr_write_en <= 1'b1;
      csr_index    <= idx;
      csr_wdata    <= 10'(val);
      @(posedge clock);
      sb.set_reg(idx, val);
      csr_write_en <= 1'b0;
      @(posedge clock);
   endtask

   task automatic configure(int w, int h, int off, int thr);
      write_reg(hla_pkg::CSR_IMAGE_WIDTH, w);
      write_reg(hla_pkg::CSR_IMAGE_HEIGHT, h);
      write_reg(hla_pkg::CSR_RHO_OFFSET, off);
      write_reg(hla_pkg::CSR_THRESHOLD, thr);
   endtask

   // read a cell that the last voting pixel touched, or a random row if that one is out of range
   task automatic read_hit();
      int t, row;
      t   = $urandom_range(0, NANG - 1);
      row = sb.rho_row(last_x, last_y, t);
      if (row < 0 || row >= RHO_ROWS) row = $urandom_range(0, RHO_ROWS - 1);
      send(hla_pkg::OP_READ, $urandom, $urandom, $urandom, row, t);
   endtask

   task automatic random_items(int n);
      int pick;
      for (int i = 0; i < n; i++) begin
         pick = $urandom_range(0, 99);
         if (pick < 50)
            send(hla_pkg::OP_VOTE, $urandom_range(0, 511), $urandom_range(0, 511),
                 ($urandom_range(0, 9) == 0) ? 255 : $urandom_range(0, 255), 0, 0);
         else if (pick < 75) read_hit();
         else if (pick < 92)
            send(hla_pkg::OP_READ, $urandom, $urandom, $urandom, $urandom_range(0, 1023),
                 $urandom_range(0, 255));
         else if (pick < 98)
            send(hla_pkg::OP_NOP, $urandom, $urandom, $urandom, $urandom, $urandom);
         else send(hla_pkg::OP_CLEAR, $urandom, $urandom, $urandom, $urandom, $urandom);
      end
   endtask

   initial begin
      sb              = new();
      last_x          = 256;
      last_y          = 256;
      reset           = 1'b1;
      start           = 1'b0;
      req_op          = hla_pkg::OP_NOP;
      req_pixel_x     = '0;
      req_pixel_y     = '0;
      req_pixel_value = '0;
      req_rho_index   = '0;
      req_angle_index = '0;
      csr_write_en    = 1'b0;
      csr_index       = hla_pkg::CSR_IMAGE_WIDTH;
      csr_wdata       = '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // directed: empty store, extremes, dropped pixels, out-of-range reads
      send(hla_pkg::OP_READ, 0, 0, 0, 362, 0);
      send(hla_pkg::OP_VOTE, 0, 0, 0, 0, 0);
      read_hit();
      send(hla_pkg::OP_VOTE, 511, 511, 254, 0, 0);
      read_hit();
      send(hla_pkg::OP_VOTE, 511, 0, 255, 0, 0);
      send(hla_pkg::OP_VOTE, 0, 511, 100, 0, 0);
      read_hit();
      send(hla_pkg::OP_VOTE, 0, 511, 100, 0, 0);
      read_hit();
      send(hla_pkg::OP_READ, 0, 0, 0, 1023, 179);
      send(hla_pkg::OP_READ, 0, 0, 0, 0, 180);
      send(hla_pkg::OP_READ, 0, 0, 0, 100, 255);
      send(hla_pkg::OP_NOP, 0, 0, 0, 0, 0);
      send(hla_pkg::OP_CLEAR, 0, 0, 0, 0, 0);
      send(hla_pkg::OP_READ, 0, 0, 0, 362, 90);
      send(hla_pkg::OP_VOTE, 256, 256, 0, 0, 0);
      read_hit();
      drain();

      configure(1, 1, 0, 0);
      send(hla_pkg::OP_VOTE, 0, 0, 0, 0, 0);
      send(hla_pkg::OP_VOTE, 511, 511, 0, 0, 0);
      read_hit();
      random_items(300);
      drain();

      configure(512, 512, 512, 255);
      random_items(300);
      drain();

      configure($urandom_range(1, 512), $urandom_range(1, 512), $urandom_range(0, 512),
                $urandom_range(0, 255));
      random_items(350);
      drain();

      configure(512, 512, 362, 150);
      random_items(350);
      drain();

      if (sb.errors == 0 && sb.pending.size() == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
